[src/sem_pkg.sv]
// Shared types and constants for the Sobel edge magnitude block.
// No dependencies.
package sem_pkg;
    localparam int MaxWidth  = 2048;
    localparam int ColW      = $clog2(MaxWidth);
    localparam int RowW      = 16;
    localparam int WidthRegW = 12;
    localparam int PixW      = 8;
    localparam int SqW       = 17;
    localparam logic [WidthRegW-1:0] WidthReset  = 12'd640;
    localparam logic [RowW-1:0]      HeightReset = 16'd480;
    localparam logic [0:0]           RegWidth    = 1'b0;
    localparam logic [0:0]           RegHeight   = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_READ = 4'b0010,
        ST_CALC = 4'b0100,
        ST_ROOT = 4'b1000
    } state_t;

    typedef struct packed {
        logic load;
        logic compute;
        logic root_start;
        logic root_step;
    } cmd_t;

    typedef struct packed {
        logic emit;
        logic root_last;
    } sts_t;
endpackage

[src/sem_datapath.sv]
// Datapath: line stores, window, position counters, gradient and square root.
// Depends on sem_pkg.
module sem_datapath
    import sem_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  cmd_t                 cmd,
    output sts_t                 sts,
    input  logic [PixW-1:0]      pixel,
    input  logic                 frame_start,
    input  logic [WidthRegW-1:0] width_cfg,
    input  logic [RowW-1:0]      height_cfg,
    input  logic                 out_load,
    output logic [PixW-1:0]      mag_word,
    output logic [ColW-1:0]      col_word,
    output logic [RowW-1:0]      row_word,
    output logic                 last_word
);
    logic [PixW-1:0] mem_mid [MaxWidth];
    logic [PixW-1:0] mem_top [MaxWidth];
    logic [PixW-1:0] mid_reg, top_reg, pix_reg;
    logic [PixW-1:0] mid_val, top_val;
    logic [PixW-1:0] win_reg [6];
    logic [ColW:0]   col_count_reg;
    logic [RowW-1:0] row_count_reg;
    logic [ColW-1:0] col_reg;
    logic [RowW-1:0] row_reg;
    logic            emit_reg, last_reg;
    logic [ColW:0]   fill_reg;
    logic            fresh_reg;
    logic [ColW:0]   eff_w;
    logic [RowW-1:0] eff_h;
    logic [ColW:0]   col_start;
    logic [RowW:0]   row_start, row_fix;
    logic [RowW-1:0] row_now;
    logic [ColW-1:0] col_now;
    logic [ColW:0]   col_inc;
    logic [RowW:0]   row_inc;
    logic [SqW-1:0]  s_reg;
    logic [PixW-1:0] r_reg;
    logic [PixW-1:0] bit_reg;
    logic [PixW-1:0] trial;
    logic signed [11:0] gx, gy;
    logic [10:0] ax, ay;
    logic [21:0] ssum;
    logic [15:0] tsq;
    logic [10:0] c_tl, c_ml, c_bl, c_tm, c_bm, c_tr, c_mr, c_br;

    // effective frame size
    always_comb
    begin
        if (width_cfg < 12'd3)
            eff_w = (ColW+1)'(3);
        else if ({1'b0, width_cfg} > 13'(MaxWidth))
            eff_w = (ColW+1)'(MaxWidth);
        else
            eff_w = (ColW+1)'(width_cfg);
        eff_h = (height_cfg < 16'd3) ? 16'd3 : height_cfg;
    end

    // position of the arriving word
    always_comb
    begin
        col_start = frame_start ? '0 : col_count_reg;
        row_start = frame_start ? '0 : {1'b0, row_count_reg};
        if (col_start >= eff_w)
        begin
            col_now = '0;
            row_fix = row_start + 1'b1;
        end
        else
        begin
            col_now = col_start[ColW-1:0];
            row_fix = row_start;
        end
        row_now = (row_fix >= {1'b0, eff_h}) ? '0 : row_fix[RowW-1:0];
        col_inc = {1'b0, col_now} + 1'b1;
        row_inc = {1'b0, row_now} + 1'b1;
    end

    // columns are always written upward from zero, so the written part of the
    // line stores is a prefix: fill_reg counts it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= '0;
            row_count_reg <= '0;
            col_reg       <= '0;
            row_reg       <= '0;
            pix_reg       <= '0;
            emit_reg      <= 1'b0;
            last_reg      <= 1'b0;
            fill_reg      <= '0;
            fresh_reg     <= 1'b1;
        end
        else if (cmd.load)
        begin
            col_reg   <= col_now;
            row_reg   <= row_now;
            pix_reg   <= pixel;
            fresh_reg <= ({1'b0, col_now} >= fill_reg);
            emit_reg  <= (row_now >= 16'd2) && (col_now >= ColW'(2));
            last_reg  <= (row_now == eff_h - 1'b1) && (col_inc == eff_w);
            if (col_inc >= eff_w)
            begin
                col_count_reg <= '0;
                row_count_reg <= (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[RowW-1:0];
            end
            else
            begin
                col_count_reg <= col_inc;
                row_count_reg <= row_now;
            end
        end
        else if (cmd.compute)
        begin
            if ({1'b0, col_reg} >= fill_reg)
                fill_reg <= {1'b0, col_reg} + 1'b1;
        end
    end

    // line store read, registered
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mid_reg <= mem_mid[col_now];
            top_reg <= mem_top[col_now];
        end
        if (cmd.compute)
        begin
            mem_top[col_reg] <= mid_val;
            mem_mid[col_reg] <= pix_reg;
        end
    end

    // a column never written since reset reads as zero
    assign mid_val = fresh_reg ? '0 : mid_reg;
    assign top_val = fresh_reg ? '0 : top_reg;

    always_comb
    begin
        c_tl = {3'b0, win_reg[0]};
        c_ml = {3'b0, win_reg[1]};
        c_bl = {3'b0, win_reg[2]};
        c_tm = {3'b0, win_reg[3]};
        c_bm = {3'b0, win_reg[5]};
        c_tr = {3'b0, top_val};
        c_mr = {3'b0, mid_val};
        c_br = {3'b0, pix_reg};
        gx = $signed({1'b0, c_tr + (c_mr << 1) + c_br})
           - $signed({1'b0, c_tl + (c_ml << 1) + c_bl});
        gy = $signed({1'b0, c_bl + (c_bm << 1) + c_br})
           - $signed({1'b0, c_tl + (c_tm << 1) + c_tr});
        ax = gx[11] ? 11'(-gx) : gx[10:0];
        ay = gy[11] ? 11'(-gy) : gy[10:0];
        ssum = {11'b0, ax} * {11'b0, ax} + {11'b0, ay} * {11'b0, ay};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.compute)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= top_val;
            win_reg[4] <= mid_val;
            win_reg[5] <= pix_reg;
            s_reg <= (ssum >= 22'd65536) ? '1 : ssum[SqW-1:0];
        end
    end

    // one result bit per step, most significant first
    assign trial = r_reg | bit_reg;
    assign tsq   = {8'b0, trial} * {8'b0, trial};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_reg   <= '0;
            bit_reg <= '0;
        end
        else if (cmd.root_start)
        begin
            r_reg   <= '0;
            bit_reg <= 8'h80;
        end
        else if (cmd.root_step)
        begin
            if (s_reg[16] || ({1'b0, tsq} <= s_reg))
                r_reg <= trial;
            bit_reg <= bit_reg >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            mag_word  <= (s_reg[16] || ({1'b0, tsq} <= s_reg)) ? trial : r_reg;
            col_word  <= col_reg - 1'b1;
            row_word  <= row_reg - 1'b1;
            last_word <= last_reg;
        end
    end

    assign sts.emit      = emit_reg;
    assign sts.root_last = bit_reg[0];
endmodule

[src/sem_ctrl.sv]
// Controller: sequences load, compute and root steps, holds output valid.
// Depends on sem_pkg.
module sem_ctrl
    import sem_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    input  sts_t sts,
    output cmd_t cmd,
    output logic out_load
);
    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        out_load       = 1'b0;
        in_ready       = 1'b0;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.compute = 1'b1;
                state_next  = sts.emit ? ST_CALC : ST_IDLE;
            end
            ST_CALC:
            begin
                cmd.root_start = 1'b1;
                state_next     = ST_ROOT;
            end
            ST_ROOT:
            begin
                // hold the last step until the output register is free
                if (!sts.root_last)
                    cmd.root_step = 1'b1;
                else if (!out_valid_reg || out_ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule

[src/sobel_edge_magnitude_core.sv]
// Sobel 3x3 edge magnitude over a raster pixel stream.
// Words are taken one at a time: in_ready stays low until the previous word is finished.
// Each word takes load and compute; an interior word also takes root setup and
// the 8-step bit-serial square root; a stalled result holds the input.
// Reset clears counters, control and sizes (640 x 480); line stores read as zero until written.
// Depends on sem_pkg, sem_ctrl, sem_datapath.
module sobel_edge_magnitude_core
    import sem_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [PixW-1:0]   pixel,
    input  logic              frame_start,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [PixW-1:0]   magnitude,
    output logic [ColW-1:0]   centre_col,
    output logic [RowW-1:0]   centre_row,
    output logic              frame_last,
    input  logic              cfg_we,
    input  logic [0:0]        cfg_index,
    input  logic [RowW-1:0]   cfg_data
);
    logic [WidthRegW-1:0] width_reg;
    logic [RowW-1:0]      height_reg;
    cmd_t cmd;
    sts_t sts;
    logic out_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WidthReset;
            height_reg <= HeightReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                RegWidth:  width_reg  <= cfg_data[WidthRegW-1:0];
                RegHeight: height_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    sem_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd),
        .out_load  (out_load)
    );

    sem_datapath u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .pixel       (pixel),
        .frame_start (frame_start),
        .width_cfg   (width_reg),
        .height_cfg  (height_reg),
        .out_load    (out_load),
        .mag_word    (magnitude),
        .col_word    (centre_col),
        .row_word    (centre_row),
        .last_word   (frame_last)
    );
endmodule
